// File: hw/rtl/vvps_pkg.sv
// ============================================================================
// vvps_pkg: shared types and constants for the Verlet particle step
// Holds the sequencer states, fixed datapath widths, divider types and sat32.
// ============================================================================
package vvps_pkg;

  localparam int unsigned DataWidth = 32;
  localparam int unsigned DtWidth   = 17;
  localparam logic [16:0] DtReset   = 17'd655;
  localparam logic [0:0]  RegTimeStep = 1'b0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_KDIV,
    ST_KADD,
    ST_DMUL,
    ST_DADD,
    ST_SQ,
    ST_SQRT,
    ST_OUT
  } vvps_state_t;

  // Command from the sequencer to the divider.
  typedef struct packed {
    logic        start;
    logic [48:0] num;
    logic [31:0] den;
  } vvps_div_req_t;

  typedef struct packed {
    logic        done;
    logic [48:0] quo;
  } vvps_div_rsp_t;

  // Saturate a 50-bit signed value to 32 bits.
  function automatic logic [31:0] sat32(input logic signed [49:0] v);
    logic [31:0] r;
    if (v > 50'sd2147483647) r = 32'h7fffffff;
    else if (v < -50'sd2147483648) r = 32'h80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// File: hw/rtl/vvps_div.sv
// ============================================================================
// vvps_div: radix-2 restoring divider
// Unsigned 49-bit by 32-bit quotient, one bit per cycle.
// ============================================================================
module vvps_div (
  input  logic                   clk,
  input  logic                   rst,
  input  vvps_pkg::vvps_div_req_t req,
  output vvps_pkg::vvps_div_rsp_t rsp
);
  import vvps_pkg::*;

  logic [48:0] quo;
  logic [32:0] rem;
  logic [5:0]  cnt;
  logic        busy;
  logic        done;
  logic [31:0] den;
  logic [33:0] trial;
  logic [32:0] shifted;

  assign shifted = {rem[31:0], quo[48]};
  assign trial   = {1'b0, shifted} - {2'b00, den};

  // Shift one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 6'd49;
        quo  <= req.num;
        rem  <= '0;
        den  <= req.den;
      end else if (busy) begin
        if (!trial[33]) begin
          rem <= trial[32:0];
          quo <= {quo[47:0], 1'b1};
        end else begin
          rem <= shifted;
          quo <= {quo[47:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp = {done, quo};

endmodule

// File: hw/rtl/velocity_verlet_particle_step_top.sv
// ============================================================================
// velocity_verlet_particle_step_top: Verlet kick/drift for one particle
// One particle per transfer; shared divider, multiplier and root sequencer.
// ============================================================================
//  channel | direction | handshake
//  in      | input     | in_valid / in_stall
//  out     | output    | out_valid / out_stall
//  apb     | input     | psel penable pwrite paddr pwdata prdata pready
// A pre-force item kicks and drifts, and when it closes a batch it also runs the
// square root (32 root steps); a post-force item only kicks.
// Each kick axis runs the 49-step divider; zero mass skips the kick.
// Reset sets time_step to 655 and clears the batch maximum.
// The result register holds while out_stall is high and no new item is taken;
// the next input transfer can follow in the cycle after the result leaves.
module velocity_verlet_particle_step_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd,
  input  logic [31:0] pos_x,
  input  logic [31:0] pos_y,
  input  logic [31:0] pos_z,
  input  logic [31:0] vel_x,
  input  logic [31:0] vel_y,
  input  logic [31:0] vel_z,
  input  logic [31:0] force_x,
  input  logic [31:0] force_y,
  input  logic [31:0] force_z,
  input  logic [30:0] mass,
  input  logic        last_particle,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] new_pos_x,
  output logic [31:0] new_pos_y,
  output logic [31:0] new_pos_z,
  output logic [31:0] new_vel_x,
  output logic [31:0] new_vel_y,
  output logic [31:0] new_vel_z,
  output logic [30:0] max_displacement,
  output logic        displacement_valid
);
  import vvps_pkg::*;

  vvps_state_t state, state_next;
  logic [16:0] time_step;
  logic [63:0] max_disp_squared;
  logic        kick_only, last;
  logic [30:0] m;
  logic [31:0] p [3];
  logic [31:0] v [3];
  logic [31:0] f [3];
  logic [33:0] d [3];
  logic [1:0]  ax;
  logic [63:0] disp_acc;
  logic [63:0] sq_x, sq_res, sq_bit;
  logic [31:0] f_mag, v_mag, d_mag;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic [64:0] dsum;
  logic        div_started;
  vvps_div_req_t dreq;
  vvps_div_rsp_t drsp;

  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == RegTimeStep) ? {15'd0, time_step} : 32'd0;
  assign in_stall = (state != ST_IDLE) || out_valid;

  // Configuration write.
  always_ff @(posedge clk) begin
    if (rst) time_step <= DtReset;
    else if (psel && penable && pwrite && pready && paddr[2] == RegTimeStep)
      time_step <= pwdata[16:0];
  end

  // Shared multiplier: dt times a force or velocity magnitude, or a squared drift.
  assign f_mag = f[ax][31] ? -f[ax] : f[ax];
  assign v_mag = v[ax][31] ? -v[ax] : v[ax];
  assign d_mag = d[ax][33] ? 32'(-d[ax]) : d[ax][31:0];
  assign mul_a = (state == ST_SQ) ? d_mag : ((state == ST_KDIV) ? f_mag : v_mag);
  assign mul_b = (state == ST_SQ) ? d_mag : {15'd0, time_step};
  assign prod  = {32'd0, mul_a} * {32'd0, mul_b};
  assign dsum  = {1'b0, disp_acc} + {1'b0, prod};

  vvps_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  // Start the divider once on entry to each kick axis.
  always_comb begin
    dreq.start = (state == ST_KDIV) && !div_started;
    dreq.num   = prod[48:0];
    dreq.den   = {m, 1'b0};
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid && !in_stall)
                 state_next = (mass == 31'd0) ? (cmd ? ST_OUT : ST_DMUL) : ST_KDIV;
      ST_KDIV: if (drsp.done) state_next = ST_KADD;
      ST_KADD: state_next = (ax != 2'd2) ? ST_KDIV : (kick_only ? ST_OUT : ST_DMUL);
      ST_DMUL: state_next = ST_DADD;
      ST_DADD: state_next = (ax != 2'd2) ? ST_DMUL : ST_SQ;
      ST_SQ:   if (ax == 2'd2) state_next = last ? ST_SQRT : ST_OUT;
      ST_SQRT: if (sq_bit == 64'd1) state_next = ST_OUT;
      ST_OUT:  state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_disp_squared <= '0;
      out_valid <= 1'b0;
      ax <= '0;
      div_started <= 1'b0;
    end else begin
      div_started <= (state == ST_KDIV);
      // Raise the result at the end of the sequence, drop it once transferred.
      if (state == ST_OUT) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: if (in_valid && !in_stall) begin
          kick_only <= cmd; last <= last_particle; m <= mass; ax <= '0;
          p[0] <= pos_x; p[1] <= pos_y; p[2] <= pos_z;
          v[0] <= vel_x; v[1] <= vel_y; v[2] <= vel_z;
          f[0] <= force_x; f[1] <= force_y; f[2] <= force_z;
          disp_acc <= '0;
        end
        ST_KDIV: ;
        ST_KADD: begin
          v[ax] <= sat32($signed({v[ax][31], v[ax][31], v[ax][31], v[ax][31],
                     v[ax][31], v[ax][31], v[ax][31], v[ax][31], v[ax][31],
                     v[ax][31], v[ax][31], v[ax][31], v[ax][31], v[ax][31],
                     v[ax][31], v[ax][31], v[ax][31], v[ax][31], v[ax]}) +
                     (f[ax][31] ? -$signed({1'b0, drsp.quo})
                                : $signed({1'b0, drsp.quo})));
          ax <= (ax == 2'd2) ? 2'd0 : ax + 2'd1;
        end
        ST_DMUL: d[ax] <= v[ax][31] ? -prod[49:16] : prod[49:16];
        ST_DADD: begin
          p[ax] <= sat32($signed({{16{d[ax][33]}}, d[ax]}) +
                         $signed({{18{p[ax][31]}}, p[ax]}));
          ax <= (ax == 2'd2) ? 2'd0 : ax + 2'd1;
        end
        ST_SQ: begin
          disp_acc <= dsum[64] ? '1 : dsum[63:0];
          ax <= (ax == 2'd2) ? 2'd0 : ax + 2'd1;
          if (ax == 2'd2) begin
            sq_x <= (dsum[64] ? '1 : dsum[63:0]) > max_disp_squared ?
                    (dsum[64] ? '1 : dsum[63:0]) : max_disp_squared;
            sq_res <= '0;
            sq_bit <= 64'h4000_0000_0000_0000;
            if (!last) max_disp_squared <= (dsum[64] ? '1 : dsum[63:0]) >
                        max_disp_squared ? (dsum[64] ? '1 : dsum[63:0]) :
                        max_disp_squared;
          end
        end
        ST_SQRT: begin
          if (sq_x >= sq_res + sq_bit) begin
            sq_x <= sq_x - (sq_res + sq_bit);
            sq_res <= (sq_res >> 1) + sq_bit;
          end else sq_res <= sq_res >> 1;
          sq_bit <= sq_bit >> 2;
          max_disp_squared <= '0;
        end
        ST_OUT: begin
          new_pos_x <= p[0]; new_pos_y <= p[1]; new_pos_z <= p[2];
          new_vel_x <= v[0]; new_vel_y <= v[1]; new_vel_z <= v[2];
          displacement_valid <= !kick_only && last;
          max_displacement <= (!kick_only && last) ?
            (sq_res > 64'h7fffffff ? 31'h7fffffff : sq_res[30:0]) : 31'd0;
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> in_stall) else $error("input taken while busy");
  a_out_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_OUT) else $error("stray result");
  a_dv_pre: assert property (@(posedge clk) disable iff (rst)
    out_valid && displacement_valid |-> !kick_only) else $error("bad flag");
`endif

endmodule
